@@ rtl/spq_pkg.sv @@
// shared types and codes for the sorted priority queue
`default_nettype none
package spq_pkg;

  localparam int TagWidth = 32;
  localparam int PriWidth = 16;
  localparam int OrdWidth = 16;
  localparam int KeyWidth = PriWidth + OrdWidth;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [TagWidth-1:0] tag;
    logic [PriWidth-1:0] pri;
    logic [OrdWidth-1:0] ord;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } cell_cmd_t;

  function automatic logic [KeyWidth-1:0] key_of(input entry_t e);
    return {e.pri, e.ord};
  endfunction

endpackage
`default_nettype wire

@@ rtl/spq_cell.sv @@
// one slot of the sorted chain: holds an entry, shifts toward either neighbor
`default_nettype none
module spq_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spq_pkg::cell_cmd_t cmd,
  input  wire spq_pkg::slot_t    left,
  input  wire logic              left_gt,
  input  wire spq_pkg::slot_t    right,
  output spq_pkg::slot_t         slot,
  output logic                   gt
);
  import spq_pkg::*;

  logic   valid;
  entry_t entry;
  logic   valid_next;
  entry_t entry_next;

  // this slot sorts behind the incoming entry
  assign gt = !valid || (key_of(entry) > key_of(cmd.entry));

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (cmd.push && gt) begin
      if (left_gt) begin
        valid_next = left.valid;
        entry_next = left.entry;
      end else begin
        valid_next = 1'b1;
        entry_next = cmd.entry;
      end
    end else if (cmd.pop) begin
      valid_next = right.valid;
      entry_next = right.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    entry <= entry_next;
  end

  assign slot.valid = valid;
  assign slot.entry = entry;

endmodule
`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// top level of the sorted priority queue: cell chain and result register
//
//   channel  direction  signals
//   in       request    in_valid, in_ready, func, job_tag, priority_req, order
//   out      result     out_valid, out_ready, status, out_tag, out_priority, out_order
//
// one request accepted per cycle while in_ready is high; its result appears in the next cycle
// every cell compares the incoming key in parallel and all cells shift together
// reset empties the chain at once, no clearing pass
// a result held by a stalled consumer blocks input only if out_ready is low
`default_nettype none
module sorted_priority_queue #(
  parameter int CAPACITY = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           func,
  input  wire logic [spq_pkg::TagWidth-1:0]   job_tag,
  input  wire logic [spq_pkg::PriWidth-1:0]   priority_req,
  input  wire logic [spq_pkg::OrdWidth-1:0]   order,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          status,
  output logic [spq_pkg::TagWidth-1:0]        out_tag,
  output logic [spq_pkg::PriWidth-1:0]        out_priority,
  output logic [spq_pkg::OrdWidth-1:0]        out_order
);
  import spq_pkg::*;

  slot_t     slots [CAPACITY];
  logic      gts   [CAPACITY];
  cell_cmd_t cmd;
  logic      accept;
  logic      full;
  logic      empty;
  status_t   status_next;
  entry_t    result_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = slots[CAPACITY-1].valid;
  assign empty    = !slots[0].valid;

  assign cmd.push      = accept && (func == FUNC_PUSH) && !full;
  assign cmd.pop       = accept && (func == FUNC_POP) && !empty;
  assign cmd.entry.tag = job_tag;
  assign cmd.entry.pri = priority_req;
  assign cmd.entry.ord = order;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_gt;

    if (i == 0) begin : g_head
      assign left_slot = '0;
      assign left_gt   = 1'b0;
    end else begin : g_mid
      assign left_slot = slots[i-1];
      assign left_gt   = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_body
      assign right_slot = slots[i+1];
    end

    spq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .left    (left_slot),
      .left_gt (left_gt),
      .right   (right_slot),
      .slot    (slots[i]),
      .gt      (gts[i])
    );
  end

  always_comb begin
    status_next = STATUS_OK;
    result_next = '0;
    if (func == FUNC_PUSH) begin
      if (full) begin
        status_next = STATUS_FULL;
      end
    end else if (empty) begin
      status_next = STATUS_EMPTY;
    end else begin
      result_next = slots[0].entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      status       <= status_next;
      out_tag      <= result_next.tag;
      out_priority <= result_next.pri;
      out_order    <= result_next.ord;
    end
  end

endmodule
`default_nettype wire
